// ===== hw/rtl/ofs_pkg.sv =====
// Shared constants, types and helper functions for the overwrite FIFO with statistics
package ofs_pkg;

  localparam int DEPTH  = 64;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 7;
  localparam int DATA_W = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;
  localparam int ACT_W  = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 2'd0,
    ACT_CONSUME   = 2'd1,
    ACT_STATS_CLR = 2'd2,
    ACT_QUERY     = 2'd3
  } action_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the input beat
    logic exec;     // apply the latched beat and load the result register
  } ofs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free; // result register empty or being taken this cycle
  } ofs_status_t;

  // Map the programmed capacity onto 1..DEPTH
  function automatic len_t eff_cap(input logic [CAP_W-1:0] cap);
    len_t res;
    if (cap == '0) begin
      res = len_t'(1);
    end else if (int'(cap) > DEPTH) begin
      res = len_t'(DEPTH);
    end else begin
      res = len_t'(cap);
    end
    return res;
  endfunction

  // Advance a ring slot, wrapping at the effective capacity
  function automatic slot_t next_slot(input slot_t slot, input len_t cap);
    len_t inc;
    inc = len_t'(slot) + len_t'(1);
    return (inc >= cap) ? '0 : inc[SLOT_W-1:0];
  endfunction

  // Saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/ofs_ctrl.sv =====
// Controller state machine: input handshake and step sequencing
module ofs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ofs_pkg::ofs_status_t status,
  output ofs_pkg::ofs_cmd_t    cmd
);
  import ofs_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands from state
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.capture = in_valid && (state_r == ST_IDLE);
    cmd.exec    = (state_r == ST_EXEC) && status.out_free;
  end

  // Next state: wait in exec until the result register can take the beat
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/ofs_dp.sv =====
// Datapath: ring store, pointers, statistics counters and result register
module ofs_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ofs_pkg::ofs_cmd_t           cmd,
  output ofs_pkg::ofs_status_t        status,
  input  logic [ofs_pkg::ACT_W-1:0]   in_action,
  input  logic [ofs_pkg::DATA_W-1:0]  in_payload,
  input  logic [ofs_pkg::TIME_W-1:0]  in_time_stamp,
  input  logic                        cfg_we,
  input  logic [ofs_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_got_item,
  output logic [ofs_pkg::DATA_W-1:0]  out_payload,
  output logic [ofs_pkg::TIME_W-1:0]  out_arrival,
  output logic                        out_dropped_now,
  output logic [ofs_pkg::LEN_W-1:0]   out_queue_length,
  output logic [ofs_pkg::CNT_W-1:0]   out_received_count,
  output logic [ofs_pkg::CNT_W-1:0]   out_processed_count,
  output logic [ofs_pkg::CNT_W-1:0]   out_lost_count,
  output logic [ofs_pkg::SUM_W-1:0]   out_wait_total,
  output logic [ofs_pkg::TIME_W-1:0]  out_period_start
);
  import ofs_pkg::*;

  // Latched input beat
  action_t           act_r;
  logic [DATA_W-1:0] pay_r;
  logic [TIME_W-1:0] ts_r;

  // Ring store and its registered read port
  logic [DATA_W-1:0] pay_mem [DEPTH];
  logic [TIME_W-1:0] arr_mem [DEPTH];
  logic [DATA_W-1:0] rd_pay_r;
  logic [TIME_W-1:0] rd_arr_r;
  logic              mem_we;

  // Ring control and statistics
  logic [CAP_W-1:0]  cap_r;
  slot_t             rd_slot_r, rd_slot_nxt;
  slot_t             wr_slot_r, wr_slot_nxt;
  len_t              fill_r, fill_nxt;
  logic [CNT_W-1:0]  recv_r, recv_nxt;
  logic [CNT_W-1:0]  proc_r, proc_nxt;
  logic [CNT_W-1:0]  lost_r, lost_nxt;
  logic [SUM_W-1:0]  wsum_r, wsum_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;

  // Result register
  logic              out_valid_r;
  logic              got_r, got_nxt;
  logic              drop_r, drop_nxt;
  logic [DATA_W-1:0] opay_r, opay_nxt;
  logic [TIME_W-1:0] oarr_r, oarr_nxt;

  len_t              cap_eff;
  logic [TIME_W-1:0] wait_ticks;
  logic [SUM_W:0]    sum_ext;

  assign cap_eff       = eff_cap(cap_r);
  assign wait_ticks    = ts_r - rd_arr_r;
  assign sum_ext       = {1'b0, wsum_r} + (SUM_W + 1)'(wait_ticks);
  assign status.out_free = !out_valid_r || out_ready;

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action_t'(in_action);
      pay_r <= in_payload;
      ts_r  <= in_time_stamp;
    end
  end

  // Write on insert, read the oldest slot every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[wr_slot_r] <= pay_r;
      arr_mem[wr_slot_r] <= ts_r;
    end
    rd_pay_r <= pay_mem[rd_slot_r];
    rd_arr_r <= arr_mem[rd_slot_r];
  end

  // Work out the step
  always_comb begin
    rd_slot_nxt = rd_slot_r;
    wr_slot_nxt = wr_slot_r;
    fill_nxt    = fill_r;
    recv_nxt    = recv_r;
    proc_nxt    = proc_r;
    lost_nxt    = lost_r;
    wsum_nxt    = wsum_r;
    start_nxt   = start_r;
    got_nxt     = 1'b0;
    drop_nxt    = 1'b0;
    opay_nxt    = '0;
    oarr_nxt    = '0;
    mem_we      = 1'b0;
    if (cmd.exec) begin
      case (act_r)
        ACT_INSERT: begin
          mem_we      = 1'b1;
          wr_slot_nxt = next_slot(wr_slot_r, cap_eff);
          recv_nxt    = sat_inc(recv_r);
          if (fill_r >= cap_eff) begin
            // drop the oldest, fill level stays at capacity
            rd_slot_nxt = next_slot(rd_slot_r, cap_eff);
            lost_nxt    = sat_inc(lost_r);
            drop_nxt    = 1'b1;
          end else begin
            fill_nxt = fill_r + len_t'(1);
          end
        end
        ACT_CONSUME: begin
          if (fill_r != '0) begin
            got_nxt     = 1'b1;
            opay_nxt    = rd_pay_r;
            oarr_nxt    = rd_arr_r;
            rd_slot_nxt = next_slot(rd_slot_r, cap_eff);
            fill_nxt    = fill_r - len_t'(1);
            proc_nxt    = sat_inc(proc_r);
            wsum_nxt    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          end
        end
        ACT_STATS_CLR: begin
          recv_nxt  = '0;
          proc_nxt  = '0;
          lost_nxt  = '0;
          wsum_nxt  = '0;
          start_nxt = ts_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold ring control and statistics; a capacity write empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_W'(DEPTH);
      rd_slot_r <= '0;
      wr_slot_r <= '0;
      fill_r    <= '0;
      recv_r    <= '0;
      proc_r    <= '0;
      lost_r    <= '0;
      wsum_r    <= '0;
      start_r   <= '0;
    end else if (cfg_we) begin
      cap_r     <= cfg_wdata;
      rd_slot_r <= '0;
      wr_slot_r <= '0;
      fill_r    <= '0;
    end else begin
      rd_slot_r <= rd_slot_nxt;
      wr_slot_r <= wr_slot_nxt;
      fill_r    <= fill_nxt;
      recv_r    <= recv_nxt;
      proc_r    <= proc_nxt;
      lost_r    <= lost_nxt;
      wsum_r    <= wsum_nxt;
      start_r   <= start_nxt;
    end
  end

  // Result valid: set on exec, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      got_r  <= got_nxt;
      drop_r <= drop_nxt;
      opay_r <= opay_nxt;
      oarr_r <= oarr_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_got_item        = got_r;
  assign out_payload         = opay_r;
  assign out_arrival         = oarr_r;
  assign out_dropped_now     = drop_r;
  assign out_queue_length    = fill_r;
  assign out_received_count  = recv_r;
  assign out_processed_count = proc_r;
  assign out_lost_count      = lost_r;
  assign out_wait_total      = wsum_r;
  assign out_period_start    = start_r;

endmodule

// ===== hw/rtl/overwrite_fifo_with_stats.sv =====
// Flow: an accepted beat is latched, then applied in the exec step, which uses
//   the registered read of the oldest ring slot and loads the result register;
//   exec waits while a result is held and not being taken. Beats are taken
//   only when idle; the next beat gets in while a result waits to be taken.
// Reset: rst_n synchronous, active low; clears pointers, fill level, statistics
//   and sets capacity to 64. The ring store is not cleared (no clearing pass).
module overwrite_fifo_with_stats (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ofs_pkg::ACT_W-1:0]   in_action,
  input  logic [ofs_pkg::DATA_W-1:0]  in_payload,
  input  logic [ofs_pkg::TIME_W-1:0]  in_time_stamp,
  input  logic                        cfg_we,
  input  logic [ofs_pkg::CAP_W-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_got_item,
  output logic [ofs_pkg::DATA_W-1:0]  out_payload,
  output logic [ofs_pkg::TIME_W-1:0]  out_arrival,
  output logic                        out_dropped_now,
  output logic [ofs_pkg::LEN_W-1:0]   out_queue_length,
  output logic [ofs_pkg::CNT_W-1:0]   out_received_count,
  output logic [ofs_pkg::CNT_W-1:0]   out_processed_count,
  output logic [ofs_pkg::CNT_W-1:0]   out_lost_count,
  output logic [ofs_pkg::SUM_W-1:0]   out_wait_total,
  output logic [ofs_pkg::TIME_W-1:0]  out_period_start
);
  import ofs_pkg::*;

  ofs_cmd_t    cmd;
  ofs_status_t status;

  // Sequence each beat
  ofs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, counters and result
  ofs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_action           (in_action),
    .in_payload          (in_payload),
    .in_time_stamp       (in_time_stamp),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_got_item        (out_got_item),
    .out_payload         (out_payload),
    .out_arrival         (out_arrival),
    .out_dropped_now     (out_dropped_now),
    .out_queue_length    (out_queue_length),
    .out_received_count  (out_received_count),
    .out_processed_count (out_processed_count),
    .out_lost_count      (out_lost_count),
    .out_wait_total      (out_wait_total),
    .out_period_start    (out_period_start)
  );

endmodule

// ===== tb/ofs_ring_checker.sv =====
`timescale 1ns / 100ps
// Checker for the overwrite FIFO with statistics: ring and counter prediction, result comparison
module ofs_ring_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [ofs_pkg::ACT_W-1:0]   in_action,
  input  logic [ofs_pkg::DATA_W-1:0]  in_payload,
  input  logic [ofs_pkg::TIME_W-1:0]  in_time_stamp,
  input  logic                        cfg_we,
  input  logic [ofs_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_got_item,
  input  logic [ofs_pkg::DATA_W-1:0]  out_payload,
  input  logic [ofs_pkg::TIME_W-1:0]  out_arrival,
  input  logic                        out_dropped_now,
  input  logic [ofs_pkg::LEN_W-1:0]   out_queue_length,
  input  logic [ofs_pkg::CNT_W-1:0]   out_received_count,
  input  logic [ofs_pkg::CNT_W-1:0]   out_processed_count,
  input  logic [ofs_pkg::CNT_W-1:0]   out_lost_count,
  input  logic [ofs_pkg::SUM_W-1:0]   out_wait_total,
  input  logic [ofs_pkg::TIME_W-1:0]  out_period_start,
  output int                          fail_count,
  output int                          pending
);
  import ofs_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic              got;
    logic [DATA_W-1:0] payload;
    logic [TIME_W-1:0] arrival;
    logic              dropped;
    len_t              qlen;
    logic [CNT_W-1:0]  received;
    logic [CNT_W-1:0]  processed;
    logic [CNT_W-1:0]  lost;
    logic [SUM_W-1:0]  wait_sum;
    logic [TIME_W-1:0] start;
  } ring_result_t;

  // Predicted ring contents and statistics
  logic [DATA_W-1:0] data_mem  [DEPTH];
  logic [TIME_W-1:0] stamp_mem [DEPTH];
  int unsigned       head, tail, level;
  logic [CAP_W-1:0]  cap_reg;
  logic [CNT_W-1:0]  rcv_cnt, prc_cnt, lost_cnt;
  logic [SUM_W-1:0]  wait_acc;
  logic [TIME_W-1:0] period_t0;

  ring_result_t result_q[$];

  // Slots actually in use: a zero register behaves as one, oversize as the full store
  function automatic int unsigned slots_in_use();
    if (cap_reg == '0) return 1;
    if (int'(cap_reg) > DEPTH) return DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic int unsigned step_slot(input int unsigned s, input int unsigned lim);
    return (s + 1 >= lim) ? 0 : s + 1;
  endfunction

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  // Apply one request to the predicted state and return the result it should give
  function automatic ring_result_t serve_request(input action_t act,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic [TIME_W-1:0] ts);
    ring_result_t      r;
    int unsigned       lim;
    logic [TIME_W-1:0] lag;
    r   = '0;
    lim = slots_in_use();
    case (act)
      ACT_INSERT: begin
        // full ring: drop the oldest before storing
        if (level >= lim) begin
          head      = step_slot(head, lim);
          lost_cnt  = count_up(lost_cnt);
          level     = level - 1;
          r.dropped = 1'b1;
        end
        data_mem[tail]  = data;
        stamp_mem[tail] = ts;
        tail    = step_slot(tail, lim);
        level   = level + 1;
        rcv_cnt = count_up(rcv_cnt);
      end
      ACT_CONSUME: begin
        if (level != 0) begin
          r.got     = 1'b1;
          r.payload = data_mem[head];
          r.arrival = stamp_mem[head];
          // wait wraps like a free-running tick counter
          lag = ts - r.arrival;
          if (SUM_W'(lag) > SUM_MAX - wait_acc) begin
            wait_acc = SUM_MAX;
          end else begin
            wait_acc = wait_acc + SUM_W'(lag);
          end
          head    = step_slot(head, lim);
          level   = level - 1;
          prc_cnt = count_up(prc_cnt);
        end
      end
      ACT_STATS_CLR: begin
        rcv_cnt   = '0;
        prc_cnt   = '0;
        lost_cnt  = '0;
        wait_acc  = '0;
        period_t0 = ts;
      end
      default: begin
      end
    endcase
    r.qlen      = len_t'(level);
    r.received  = rcv_cnt;
    r.processed = prc_cnt;
    r.lost      = lost_cnt;
    r.wait_sum  = wait_acc;
    r.start     = period_t0;
    return r;
  endfunction

  // Count every mismatch, print only the first hundred
  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] seen,
                             input logic [63:0] want);
    if (seen !== want) begin
      report($sformatf("%s got %0h, expected %0h", name, seen, want));
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      head       = 0;
      tail       = 0;
      level      = 0;
      cap_reg    = CAP_W'(DEPTH);
      rcv_cnt    = '0;
      prc_cnt    = '0;
      lost_cnt   = '0;
      wait_acc   = '0;
      period_t0  = '0;
      fail_count = 0;
      result_q.delete();
    end else begin
      // a capacity write empties the ring, statistics stay
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        head    = 0;
        tail    = 0;
        level   = 0;
      end
      // compare the result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = result_q.pop_front();
          check_field("got_item",        64'(out_got_item),        64'(want.got));
          check_field("payload",         64'(out_payload),         64'(want.payload));
          check_field("arrival",         64'(out_arrival),         64'(want.arrival));
          check_field("dropped_now",     64'(out_dropped_now),     64'(want.dropped));
          check_field("queue_length",    64'(out_queue_length),    64'(want.qlen));
          check_field("received_count",  64'(out_received_count),  64'(want.received));
          check_field("processed_count", 64'(out_processed_count), 64'(want.processed));
          check_field("lost_count",      64'(out_lost_count),      64'(want.lost));
          check_field("wait_total",      64'(out_wait_total),      64'(want.wait_sum));
          check_field("period_start",    64'(out_period_start),    64'(want.start));
        end
      end
      // predict the result of each accepted request beat
      if (in_valid && in_ready) begin
        result_q.push_back(serve_request(action_t'(in_action), in_payload, in_time_stamp));
      end
    end
    pending <= result_q.size();
  end

endmodule

// ===== tb/overwrite_fifo_with_stats_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the overwrite FIFO with statistics: stimulus, idling and verdict
module overwrite_fifo_with_stats_tb;
  import ofs_pkg::*;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [ACT_W-1:0]   in_action = '0;
  logic [DATA_W-1:0]  in_payload = '0;
  logic [TIME_W-1:0]  in_time_stamp = '0;
  logic               cfg_we    = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_got_item;
  logic [DATA_W-1:0]  out_payload;
  logic [TIME_W-1:0]  out_arrival;
  logic               out_dropped_now;
  logic [LEN_W-1:0]   out_queue_length;
  logic [CNT_W-1:0]   out_received_count;
  logic [CNT_W-1:0]   out_processed_count;
  logic [CNT_W-1:0]   out_lost_count;
  logic [SUM_W-1:0]   out_wait_total;
  logic [TIME_W-1:0]  out_period_start;

  int                 fail_count;
  int                 pending;
  logic               quiet = 1'b0;
  logic [TIME_W-1:0]  clock_now;

  overwrite_fifo_with_stats u_dut (.*);

  ofs_ring_checker u_check (.*);

  always #10 clk = ~clk;

  // Result side: stall at random unless in a quiet stretch
  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 12);
  end

  // Present one request beat, with random idle cycles ahead of it, and hold until taken
  task automatic send_beat(input action_t act, input logic [DATA_W-1:0] data,
                           input logic [TIME_W-1:0] ts);
    while (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_payload    <= data;
    in_time_stamp <= ts;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] cap_tab [8];
    logic [CAP_W-1:0] cap;
    action_t          act;
    int               n;
    int               pick;
    cap_tab   = '{7'd3, 7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd40, 7'd5};
    clock_now = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty ring, field extremes, wrapped waits, statistics reset
    send_beat(ACT_CONSUME, '1, '1);
    send_beat(ACT_QUERY, '1, '1);
    send_beat(ACT_INSERT, '1, '1);
    send_beat(ACT_INSERT, '0, '0);
    send_beat(ACT_INSERT, 32'h5a5a_5a5a, 32'd100);
    send_beat(ACT_CONSUME, '0, '0);
    send_beat(ACT_CONSUME, '1, '1);
    send_beat(ACT_STATS_CLR, '0, '1);
    send_beat(ACT_QUERY, '0, '0);
    send_beat(ACT_CONSUME, 32'h1234_5678, 32'd200);
    send_beat(ACT_CONSUME, '0, 32'd300);

    // Zero capacity behaves as a single slot: the second insert overwrites the first
    write_capacity('0);
    send_beat(ACT_INSERT, 32'hdead_0001, 32'd10);
    send_beat(ACT_INSERT, 32'hdead_0002, 32'd20);
    send_beat(ACT_CONSUME, '0, 32'd25);
    send_beat(ACT_CONSUME, '0, 32'd30);

    // Two slots: fill, overwrite, then drain past empty
    write_capacity(7'd2);
    send_beat(ACT_INSERT, 32'ha000_0001, 32'd1);
    send_beat(ACT_INSERT, 32'ha000_0002, 32'd2);
    send_beat(ACT_INSERT, 32'ha000_0003, 32'd3);
    send_beat(ACT_CONSUME, '0, 32'd7);
    send_beat(ACT_CONSUME, '0, 32'd9);
    send_beat(ACT_CONSUME, '0, 32'd11);
    send_beat(ACT_STATS_CLR, '1, '0);

    // Random phases over several capacities; large rings get insert-heavy traffic
    for (int p = 0; p < 8; p++) begin
      cap = (p == 6) ? CAP_W'($urandom_range(0, 127)) : cap_tab[p];
      write_capacity(cap);
      quiet <= (p == 2);
      n = (cap >= 60) ? 80 : 30;
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < ((n == 80) ? 85 : 50)) begin
          act = ACT_INSERT;
        end else if (pick < 92) begin
          act = ACT_CONSUME;
        end else if (pick < 96) begin
          act = ACT_STATS_CLR;
        end else begin
          act = ACT_QUERY;
        end
        clock_now = clock_now + $urandom_range(0, 40);
        send_beat(act, $urandom, ($urandom_range(0, 9) == 0) ? $urandom : clock_now);
      end
    end

    // Long waits: each insert/consume pair adds a wait of 2^32 - 1
    write_capacity(CAP_W'(DEPTH));
    quiet <= 1'b1;
    send_beat(ACT_STATS_CLR, '0, '0);
    for (int j = 0; j < 8; j++) begin
      send_beat(ACT_INSERT, DATA_W'(j), 32'd1);
      send_beat(ACT_CONSUME, $urandom, 32'd0);
    end
    send_beat(ACT_STATS_CLR, $urandom, $urandom);
    send_beat(ACT_QUERY, $urandom, $urandom);

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS overwrite_fifo_with_stats");
    end else begin
      $display("FAIL overwrite_fifo_with_stats");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run
  initial begin
    #30_000_000;
    $display("FAIL overwrite_fifo_with_stats");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ofs_pkg.sv
hw/rtl/ofs_ctrl.sv
hw/rtl/ofs_dp.sv
hw/rtl/overwrite_fifo_with_stats.sv
tb/ofs_ring_checker.sv
tb/overwrite_fifo_with_stats_tb.sv
